FILE: rtl/tasr_pkg.sv
// ----------------------------------------------------------------------------
// tasr_pkg
// Shared types, codes, register defaults and helpers of the setpoint ramp.
// ----------------------------------------------------------------------------
package tasr_pkg;

  localparam int unsigned AXES = 3;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_ACTIVATE = 3'd1,
    KIND_IDLE     = 3'd2,
    KIND_VELOCITY = 3'd3,
    KIND_OFFSET   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_VELOCITY = 2'd1,
    MODE_OFFSET   = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_STEP        = 3'd0,
    CFG_OFFSET_MAX_SPEED  = 3'd1,
    CFG_OFFSET_ACCEL_STEP = 3'd2,
    CFG_OFFSET_BRAKE_STEP = 3'd3,
    CFG_SNAP_DISTANCE     = 3'd4,
    CFG_BRAKE_DISTANCE    = 3'd5,
    CFG_RESTART_SPEED     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [16:0] accel_step;
    logic [19:0] offset_max_speed;
    logic [16:0] offset_accel_step;
    logic [16:0] offset_brake_step;
    logic [19:0] snap_distance;
    logic [19:0] brake_distance;
    logic [16:0] restart_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    accel_step:        17'd6554,
    offset_max_speed:  20'd131072,
    offset_accel_step: 17'd3932,
    offset_brake_step: 17'd7864,
    snap_distance:     20'd3277,
    brake_distance:    20'd134349,
    restart_speed:     17'd5243
  };

  // per-transfer command decode shared by all lanes
  typedef struct packed {
    logic  load_pos;
    logic  load_tv;
    logic  load_goal;
    mode_e mode;
  } lane_ctrl_t;

  localparam logic signed [35:0] SAT_HI = 36'sh07fffffff;
  localparam logic signed [35:0] SAT_LO = 36'shf80000000;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/three_axis_setpoint_ramp.sv
// ----------------------------------------------------------------------------
// three_axis_setpoint_ramp
// Three-axis Q16.16 position setpoint generator with velocity and offset modes.
// ----------------------------------------------------------------------------
// Takes one control tick per clock cycle; its result appears on the master side
// in the cycle after the transfer and is held until taken. While a result waits
// the slave side is not ready; a new tick is accepted in the same cycle that
// the waiting result is taken. Each axis has its own lane that applies the
// command, runs the offset approach or velocity slew and updates the setpoint
// with a single 33x18 multiplier, so the per-axis setpoint feedback loop sets
// the rate of one tick per cycle. The user must write registers through the
// plain write port while no tick is in flight; the block does not enforce it.
module three_axis_setpoint_ramp import tasr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // cmd_x, cmd_y, cmd_z, pos_x, pos_y, pos_z, step_time, zero pad
  input  logic [215:0]        s_axis_tdata_i,
  // kind
  input  logic [2:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // set_x, set_y, set_z
  output logic [95:0]         m_axis_tdata_o,
  // drive_mode
  output logic [1:0]          m_axis_tuser_o
);

  cfg_t               cfg_q;
  mode_e              mode_q, mode_d;
  kind_e              kind;
  lane_ctrl_t         ctrl;
  logic               s_xfer;
  logic signed [31:0] cmd_in [3];
  logic signed [31:0] pos_in [3];
  logic signed [31:0] lane_cmd [AXES];
  logic signed [31:0] lane_pos [AXES];
  logic signed [31:0] lane_sp [AXES];
  logic        [16:0] dt;

  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign kind   = kind_e'(s_axis_tuser_i);
  assign dt     = s_axis_tdata_i[208:192];

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign cmd_in[i] = s_axis_tdata_i[i*32 +: 32];
    assign pos_in[i] = s_axis_tdata_i[96 + i*32 +: 32];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_STEP:        cfg_q.accel_step        <= cfg_wdata_i[16:0];
        CFG_OFFSET_MAX_SPEED:  cfg_q.offset_max_speed  <= cfg_wdata_i;
        CFG_OFFSET_ACCEL_STEP: cfg_q.offset_accel_step <= cfg_wdata_i[16:0];
        CFG_OFFSET_BRAKE_STEP: cfg_q.offset_brake_step <= cfg_wdata_i[16:0];
        CFG_SNAP_DISTANCE:     cfg_q.snap_distance     <= cfg_wdata_i;
        CFG_BRAKE_DISTANCE:    cfg_q.brake_distance    <= cfg_wdata_i;
        CFG_RESTART_SPEED:     cfg_q.restart_speed     <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  // drive mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    mode_d = mode_q;
    if (s_xfer) begin
      unique case (kind) inside
        KIND_ACTIVATE, KIND_IDLE: mode_d = MODE_IDLE;
        KIND_VELOCITY:            mode_d = MODE_VELOCITY;
        KIND_OFFSET:              mode_d = MODE_OFFSET;
        default:                  mode_d = mode_q;
      endcase
    end
  end

  always_comb begin
    ctrl.load_pos  = (kind == KIND_ACTIVATE) || (kind == KIND_OFFSET);
    ctrl.load_tv   = (kind == KIND_VELOCITY);
    ctrl.load_goal = (kind == KIND_OFFSET);
    ctrl.mode      = mode_d;
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    if (i < 3) begin : g_meas
      assign lane_cmd[i] = cmd_in[i];
      assign lane_pos[i] = pos_in[i];
    end else begin : g_extra
      assign lane_cmd[i] = 32'sd0;
      assign lane_pos[i] = 32'sd0;
    end

    tasr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (s_xfer),
      .ctrl_i   (ctrl),
      .cfg_i    (cfg_q),
      .cmd_i    (lane_cmd[i]),
      .pos_i    (lane_pos[i]),
      .dt_i     (dt),
      .sp_o     (lane_sp[i])
    );
  end

  tasr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_xfer_i   (s_xfer),
    .lane_sp_i   (lane_sp),
    .mode_i      (mode_d),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .in_ready_o  (s_axis_tready_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> m_axis_tvalid_o)
    else $error("no result after input transfer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

  a_activate_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && kind == KIND_ACTIVATE) |=>
      (m_axis_tdata_o[31:0] == $past(s_axis_tdata_i[127:96])) &&
      (m_axis_tuser_o == MODE_IDLE))
    else $error("activate did not load measured position");

endmodule

FILE: rtl/tasr_lane.sv
// ----------------------------------------------------------------------------
// tasr_lane
// One axis: command load, offset approach, velocity slew and integration.
// ----------------------------------------------------------------------------
module tasr_lane import tasr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  lane_ctrl_t         ctrl_i,
  input  cfg_t               cfg_i,
  input  logic signed [31:0] cmd_i,
  input  logic signed [31:0] pos_i,
  input  logic        [16:0] dt_i,
  output logic signed [31:0] sp_o
);

  logic signed [31:0] sp_q, sp_d, vel_q, vel_d, tv_q, tv_d, goal_q, goal_d;
  logic        [20:0] spd_q, spd_d;

  logic signed [31:0] sp0, vel0, tv0, tv1, goal0;
  logic        [20:0] spd0, spd1, spd_b;
  logic        [21:0] spd_sum;
  logic signed [22:0] spd_sub;
  logic               off, spd_lt, snap_hit, brake_hit, up, down;
  logic signed [32:0] diff, dv;
  logic        [32:0] dist_abs, adv;
  logic               step_ok, integ, move;
  logic        [31:0] av;
  logic        [35:0] lhs;
  logic        [20:0] rhs;
  logic signed [32:0] op_a;
  logic signed [50:0] prod;
  logic signed [34:0] q;
  logic signed [35:0] delta;

  always_comb begin
    off   = (ctrl_i.mode == MODE_OFFSET);
    sp0   = ctrl_i.load_pos ? pos_i : sp_q;
    vel0  = ctrl_i.load_pos ? 32'sd0 : vel_q;
    tv0   = ctrl_i.load_pos ? 32'sd0 : (ctrl_i.load_tv ? cmd_i : tv_q);
    goal0 = ctrl_i.load_goal
          ? sat32({{4{pos_i[31]}}, pos_i} + {{4{cmd_i[31]}}, cmd_i}) : goal_q;
    spd0  = ctrl_i.load_goal ? 21'd0 : spd_q;
    tv1   = (ctrl_i.mode == MODE_IDLE) ? 32'sd0 : tv0;

    // offset approach
    spd_lt    = spd0 < {1'b0, cfg_i.offset_max_speed};
    spd_sum   = {1'b0, spd0} + {5'd0, cfg_i.offset_accel_step};
    spd1      = spd_lt ? spd_sum[20:0] : spd0;
    diff      = {goal0[31], goal0} - {sp0[31], sp0};
    dist_abs  = diff[32] ? -diff : diff;
    snap_hit  = dist_abs < {13'd0, cfg_i.snap_distance};
    brake_hit = dist_abs < {13'd0, cfg_i.brake_distance};
    spd_sub   = $signed({2'b00, spd1}) - $signed({6'd0, cfg_i.offset_brake_step});
    spd_b     = spd_sub[22] ? {4'd0, cfg_i.restart_speed} : spd_sub[20:0];
    up        = !diff[32] && (diff != 33'sd0);
    down      = diff[32];

    if (!off) begin
      spd_d = spd0;
    end else if (!snap_hit && brake_hit) begin
      spd_d = spd_b;
    end else begin
      spd_d = spd1;
    end

    // velocity slew
    dv      = {tv1[31], tv1} - {vel0[31], vel0};
    adv     = dv[32] ? -dv : dv;
    step_ok = adv >= {15'd0, cfg_i.accel_step, 1'b0};
    if (step_ok && !dv[32] && (dv != 33'sd0)) begin
      vel_d = sat32({{4{vel0[31]}}, vel0} + {19'd0, cfg_i.accel_step});
    end else if (step_ok && dv[32]) begin
      vel_d = sat32({{4{vel0[31]}}, vel0} - {19'd0, cfg_i.accel_step});
    end else begin
      vel_d = vel0;
    end

    av    = vel_d[31] ? -vel_d : vel_d;
    lhs   = {1'b0, av, 3'b000} + {3'b000, av, 1'b0};
    rhs   = {1'b0, cfg_i.accel_step, 3'b000} + {4'd0, cfg_i.accel_step};
    integ = lhs >= {15'd0, rhs};

    // one multiplier: offset speed or slewed velocity times step time
    op_a  = off ? $signed({12'd0, spd_d}) : $signed({vel_d[31], vel_d});
    prod  = op_a * $signed({1'b0, dt_i});
    q     = prod[50:16];
    delta = (off && down) ? -{q[34], q} : {q[34], q};
    move  = off ? (!snap_hit && (up || down)) : integ;

    if (off && snap_hit) begin
      sp_d = goal0;
    end else if (move) begin
      sp_d = sat32({{4{sp0[31]}}, sp0} + delta);
    end else begin
      sp_d = sp0;
    end

    tv_d   = tv1;
    goal_d = goal0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      vel_q  <= '0;
      tv_q   <= '0;
      goal_q <= '0;
      spd_q  <= '0;
    end else if (accept_i) begin
      sp_q   <= sp_d;
      vel_q  <= vel_d;
      tv_q   <= tv_d;
      goal_q <= goal_d;
      spd_q  <= spd_d;
    end
  end

  assign sp_o = sp_d;

endmodule

FILE: rtl/tasr_merge.sv
// ----------------------------------------------------------------------------
// tasr_merge
// Collects the lane setpoints and mode into the registered result stage.
// ----------------------------------------------------------------------------
module tasr_merge import tasr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_xfer_i,
  input  logic signed [31:0] lane_sp_i [AXES],
  input  mode_e              mode_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic        [95:0] out_data_o,
  output logic         [1:0] out_user_o,
  output logic               in_ready_o
);

  logic        valid_q, valid_d;
  logic [95:0] data_q, packed_d;
  mode_e       mode_q;

  for (genvar i = 0; i < 3; i++) begin : g_pack
    if (i < AXES) begin : g_axis
      assign packed_d[i*32 +: 32] = lane_sp_i[i];
    end else begin : g_none
      assign packed_d[i*32 +: 32] = 32'd0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_xfer_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer_i) begin
      data_q <= packed_d;
      mode_q <= mode_i;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = mode_q;

endmodule
